// ===== sv/bdte_pkg.sv =====
// shared types, constants and month table for the broken-down time converter
package bdte_pkg;

    // field widths
    localparam int unsigned YEAR_W   = 9;
    localparam int unsigned MONTH_W  = 8;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned EPOCH_W  = 36;

    // internal widths
    localparam int unsigned CAL_YEAR_W = 12;  // full calendar year 1889..2421
    localparam int unsigned TOD_W      = 17;  // linear seconds of the day part
    localparam int unsigned DAYS_W     = 19;  // signed day count from the epoch
    localparam int unsigned DSUM_W     = 22;  // day count working width

    // first stage: month offset by eleven years of months and its quotient by twelve
    typedef struct packed {
        logic [YEAR_W-1:0]   years;
        logic [8:0]          mon_ofs;
        logic [4:0]          mon_q;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } fold_t;

    // second stage: folded calendar year and month, century quotients, time of day
    typedef struct packed {
        logic [CAL_YEAR_W-1:0] year;
        logic [CAL_YEAR_W-1:0] prev_year;
        logic [4:0]            prev_cent;
        logic [4:0]            year_cent;
        logic [3:0]            month;
        logic [DAY_W-1:0]      day;
        logic [TOD_W-1:0]      tod;
    } cal_t;

    // third stage: signed day count and time of day
    typedef struct packed {
        logic signed [DAYS_W-1:0] days;
        logic [TOD_W-1:0]         tod;
    } dcount_t;

    // folding of the month: offset that makes the lowest month non-negative
    localparam logic [8:0]  MON_OFS   = 9'd132;   // eleven years of months
    localparam logic [9:0]  RECIP_12  = 10'd683;  // 2^13 / 12, rounded up
    localparam int unsigned RECIP_12_SH = 13;
    localparam logic [CAL_YEAR_W-1:0] YEAR_BIAS = 12'd1889;  // 1900 minus eleven

    // division by one hundred on a year
    localparam logic [12:0] RECIP_100   = 13'd5243;  // 2^19 / 100, rounded up
    localparam int unsigned RECIP_100_SH = 19;

    // days before 1970 plus the one taken for a day count from one
    localparam logic [DSUM_W-1:0] EPOCH_DAYS_P1 = 22'd719163;
    localparam logic [DSUM_W-1:0] DAYS_PER_YEAR = 22'd365;
    localparam logic signed [EPOCH_W-1:0] SECS_PER_DAY = 36'sd86400;

    // days before the first of a month, plain and leap year
    function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] month);
        logic [8:0] d;
        begin
            case (month)
                4'd0:    d = 9'd0;
                4'd1:    d = 9'd31;
                4'd2:    d = leap ? 9'd60  : 9'd59;
                4'd3:    d = leap ? 9'd91  : 9'd90;
                4'd4:    d = leap ? 9'd121 : 9'd120;
                4'd5:    d = leap ? 9'd152 : 9'd151;
                4'd6:    d = leap ? 9'd182 : 9'd181;
                4'd7:    d = leap ? 9'd213 : 9'd212;
                4'd8:    d = leap ? 9'd244 : 9'd243;
                4'd9:    d = leap ? 9'd274 : 9'd273;
                4'd10:   d = leap ? 9'd305 : 9'd304;
                4'd11:   d = leap ? 9'd335 : 9'd334;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

endpackage

// ===== sv/bdte_year_fold.sv =====
// month folding into the year, century quotients and linear time of day
module bdte_year_fold (
    input  logic                          clk,
    input  logic                          en,
    input  logic [bdte_pkg::YEAR_W-1:0]   years_since_1900,
    input  logic [bdte_pkg::MONTH_W-1:0]  month_raw,
    input  logic [bdte_pkg::DAY_W-1:0]    day_of_month,
    input  logic [bdte_pkg::HOUR_W-1:0]   hour,
    input  logic [bdte_pkg::MINUTE_W-1:0] minute,
    input  logic [bdte_pkg::SECOND_W-1:0] second,
    output bdte_pkg::cal_t                cal
);
    import bdte_pkg::*;

    fold_t       fold_reg;
    fold_t       fold_next;
    cal_t        cal_reg;
    cal_t        cal_next;
    logic [18:0] q12_prod;
    logic [8:0]  mon_sum;
    logic [24:0] prev_prod;
    logic [24:0] year_prod;

    // month plus 132 is never negative; its quotient by twelve by reciprocal
    always_comb
    begin
        mon_sum   = {1'b0, ~month_raw[7], month_raw[6:0]} + 9'd4;
        q12_prod  = 19'(mon_sum) * 19'(RECIP_12);
        fold_next.years   = years_since_1900;
        fold_next.mon_ofs = mon_sum;
        fold_next.mon_q   = q12_prod[17:RECIP_12_SH];
        fold_next.day     = day_of_month;
        fold_next.hour    = hour;
        fold_next.minute  = minute;
        fold_next.second  = second;
    end

    // folded year and month, year over one hundred, seconds of the day
    always_comb
    begin
        cal_next.year      = 12'(fold_reg.years) + YEAR_BIAS + 12'(fold_reg.mon_q);
        cal_next.prev_year = cal_next.year - 12'd1;
        cal_next.month     = 4'(fold_reg.mon_ofs - 9'(fold_reg.mon_q) * 9'd12);
        prev_prod          = 25'(cal_next.prev_year) * 25'(RECIP_100);
        year_prod          = 25'(cal_next.year) * 25'(RECIP_100);
        cal_next.prev_cent = prev_prod[23:RECIP_100_SH];
        cal_next.year_cent = year_prod[23:RECIP_100_SH];
        cal_next.day       = fold_reg.day;
        cal_next.tod       = 17'(fold_reg.hour) * 17'd3600
                           + 17'(fold_reg.minute) * 17'd60
                           + 17'(fold_reg.second);
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fold_reg <= fold_next;
            cal_reg  <= cal_next;
        end
    end

    assign cal = cal_reg;

endmodule

// ===== sv/bdte_day_count.sv =====
// gregorian day count from the epoch with leap rule and month table
module bdte_day_count (
    input  logic                clk,
    input  logic                en,
    input  bdte_pkg::cal_t      cal,
    output bdte_pkg::dcount_t   dcount
);
    import bdte_pkg::*;

    dcount_t           dcount_reg;
    dcount_t           dcount_next;
    logic              cent_year;
    logic              leap;
    logic [DSUM_W-1:0] dsum;

    // leap rule: by four, and by four hundred on a century year
    always_comb
    begin
        cent_year = (cal.year == 12'(cal.year_cent) * 12'd100);
        leap      = (cal.year[1:0] == 2'd0) && (!cent_year || (cal.year_cent[1:0] == 2'd0));
    end

    // days before the year, month table and day of month, wrapping in two's complement
    always_comb
    begin
        dsum = 22'(cal.prev_year) * DAYS_PER_YEAR
             + 22'(cal.prev_year[CAL_YEAR_W-1:2])
             + 22'(cal.prev_cent[4:2])
             - 22'(cal.prev_cent)
             + 22'(cum_days(leap, cal.month))
             + 22'(cal.day)
             - EPOCH_DAYS_P1;
        dcount_next.days = signed'(dsum[DAYS_W-1:0]);
        dcount_next.tod  = cal.tod;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dcount_reg <= dcount_next;
        end
    end

    assign dcount = dcount_reg;

endmodule

// ===== sv/bdte_sec_scale.sv =====
// day count to seconds and addition of the time of day
module bdte_sec_scale (
    input  logic                               clk,
    input  logic                               en,
    input  bdte_pkg::dcount_t                  dcount,
    output logic signed [bdte_pkg::EPOCH_W-1:0] epoch_seconds
);
    import bdte_pkg::*;

    logic signed [EPOCH_W-1:0] secs_reg;
    logic signed [EPOCH_W-1:0] secs_next;
    logic signed [EPOCH_W-1:0] days_ext;

    // days times 86400 plus seconds of the day
    always_comb
    begin
        days_ext  = {{(EPOCH_W-DAYS_W){dcount.days[DAYS_W-1]}}, dcount.days};
        secs_next = days_ext * SECS_PER_DAY
                  + signed'({{(EPOCH_W-TOD_W){1'b0}}, dcount.tod});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            secs_reg <= secs_next;
        end
    end

    assign epoch_seconds = secs_reg;

endmodule

// ===== sv/broken_down_time_to_epoch_seconds.sv =====
// broken-down utc time to signed seconds since 1970-01-01, four-stage pipeline
// an accepted request moves through the fold, calendar, day count and seconds registers
// throughput: one request per cycle; the whole pipeline holds while the output stalls
// the stall toward the input is the output stall gated by a waiting result
// reset clears only the stage valid bits; data registers keep no reset
module broken_down_time_to_epoch_seconds (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [bdte_pkg::YEAR_W-1:0]          years_since_1900,
    input  logic signed [bdte_pkg::MONTH_W-1:0]  month_raw,
    input  logic [bdte_pkg::DAY_W-1:0]           day_of_month,
    input  logic [bdte_pkg::HOUR_W-1:0]          hour,
    input  logic [bdte_pkg::MINUTE_W-1:0]        minute,
    input  logic [bdte_pkg::SECOND_W-1:0]        second,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [bdte_pkg::EPOCH_W-1:0]  epoch_seconds
);
    import bdte_pkg::*;

    localparam int unsigned STAGES = 4;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic              advance;
    cal_t              cal;
    dcount_t           dcount;

    // pipeline moves unless a finished result is held at the output
    assign advance  = !(vld_reg[STAGES-1] && out_stall);
    assign in_stall = !advance;
    assign vld_next = {vld_reg[STAGES-2:0], in_valid};

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_next;
        end
    end

    bdte_year_fold u_year_fold (
        .clk              (clk),
        .en               (advance),
        .years_since_1900 (years_since_1900),
        .month_raw        (month_raw),
        .day_of_month     (day_of_month),
        .hour             (hour),
        .minute           (minute),
        .second           (second),
        .cal              (cal)
    );

    bdte_day_count u_day_count (
        .clk    (clk),
        .en     (advance),
        .cal    (cal),
        .dcount (dcount)
    );

    bdte_sec_scale u_sec_scale (
        .clk           (clk),
        .en            (advance),
        .dcount        (dcount),
        .epoch_seconds (epoch_seconds)
    );

    assign out_valid = vld_reg[STAGES-1];

    // input is held back only behind a waiting result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting result");

    // an accepted request occupies the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted request lost at first stage");

    // a held pipeline keeps every stage
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(vld_reg))
        else $error("stage valid changed during stall");

    // while the pipeline advances, the output valid is registered from the last inner stage
    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |=> (out_valid == $past(vld_reg[STAGES-2])))
        else $error("result valid out of step with pipeline");

endmodule
